@@ src/krwl_pkg.sv @@
// Package for the keyed reader/writer lock table.
// Holds the field widths, word types, opcodes and status codes.
// No dependencies.
package krwl_pkg;

    localparam int KEY_W = 64;
    localparam int REQ_W = 22;
    localparam int HND_W = 4;
    localparam int ST_W = 3;

    localparam logic [1:0] OP_LOCK_SH = 2'd0;
    localparam logic [1:0] OP_LOCK_EX = 2'd1;
    localparam logic [1:0] OP_UNLOCK = 2'd2;
    localparam logic [1:0] OP_QUERY = 2'd3;

    localparam logic [ST_W-1:0] ST_GRANTED = 3'd0;
    localparam logic [ST_W-1:0] ST_BLOCKED = 3'd1;
    localparam logic [ST_W-1:0] ST_FULL = 3'd2;
    localparam logic [ST_W-1:0] ST_OVERFLOW = 3'd3;
    localparam logic [ST_W-1:0] ST_RELEASED = 3'd4;
    localparam logic [ST_W-1:0] ST_MISUSE = 3'd5;
    localparam logic [ST_W-1:0] ST_QUERY = 3'd6;

    typedef struct packed {
        logic [1:0] opcode;
        logic [KEY_W-1:0] lock_key;
        logic [REQ_W-1:0] requester;
        logic [HND_W-1:0] handle_in;
    } t_in_word;

    typedef struct packed {
        logic [ST_W-1:0] status;
        logic [HND_W-1:0] handle_out;
        logic is_held;
        logic wake_waiters;
    } t_out_word;

endpackage

@@ src/krwl_mem.sv @@
// Entry memory of the lock table: one write port and one registered read port.
// Each row holds the key, the three counts and the owner. Uses no package.
module krwl_mem #(
    parameter int DEPTH = 16,
    parameter int WIDTH = 8
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

@@ src/keyed_rw_lock_table.sv @@
// Keyed reader/writer lock table: one result word per input word.
// Lock and query words scan all ENTRIES rows of the entry memory, one read a cycle;
// unlock words read only the row that their handle names.
// One item is in work at a time; the next word enters only once the result word
// has been taken. Reset clears all valid bits and the control state.
// Depends on krwl_pkg and krwl_mem.
module keyed_rw_lock_table #(
    parameter int ENTRIES = 16,
    parameter int COUNT_BITS = 16
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    output logic                 o_ready,
    input  krwl_pkg::t_in_word   i_data,
    output logic                 o_valid,
    input  logic                 i_ready,
    output krwl_pkg::t_out_word  o_data
);

    localparam int AW = $clog2(ENTRIES);
    localparam int ROW_W = krwl_pkg::KEY_W + 3 * COUNT_BITS + krwl_pkg::REQ_W;
    localparam logic [COUNT_BITS-1:0] CMAX = '1;

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_SCAN = 3'd1;
    localparam logic [2:0] S_READ = 3'd2;
    localparam logic [2:0] S_EXEC = 3'd3;
    localparam logic [2:0] S_OUT = 3'd4;

    typedef struct packed {
        logic [krwl_pkg::KEY_W-1:0] key;
        logic [COUNT_BITS-1:0] refs;
        logic [COUNT_BITS-1:0] rd;
        logic [COUNT_BITS-1:0] wr;
        logic [krwl_pkg::REQ_W-1:0] owner;
    } t_row;

    logic [2:0] r_state;
    krwl_pkg::t_in_word r_req;
    logic [ENTRIES-1:0] r_valid_bits;
    logic [AW:0] r_scan;
    logic [AW-1:0] r_raddr_q;
    logic r_rd_pend;
    logic r_hit;
    logic r_held;
    logic [AW-1:0] r_hit_idx;
    t_row r_hit_row;
    logic r_ovalid;
    krwl_pkg::t_out_word r_odata;

    logic we;
    logic [AW-1:0] waddr;
    logic [AW-1:0] raddr;
    t_row wrow;
    t_row rrow;
    logic [ROW_W-1:0] rdata;

    krwl_mem #(.DEPTH(ENTRIES), .WIDTH(ROW_W)) u_mem (
        .i_clk  (i_clk),
        .i_we   (we),
        .i_waddr(waddr),
        .i_wdata(wrow),
        .i_raddr(raddr),
        .o_rdata(rdata)
    );

    assign rrow = t_row'(rdata);
    assign o_ready = (r_state == S_IDLE) && !r_ovalid;
    assign o_valid = r_ovalid;
    assign o_data = r_odata;

    always_comb begin
        raddr = r_scan[AW-1:0];
        if (r_state == S_READ) begin
            raddr = r_hit_idx;
        end
    end

    logic [AW-1:0] free_idx;
    logic free_any;
    always_comb begin
        free_idx = '0;
        free_any = 1'b0;
        for (int i = ENTRIES - 1; i >= 0; i--) begin
            if (!r_valid_bits[i]) begin
                free_idx = AW'(i);
                free_any = 1'b1;
            end
        end
    end

    logic [31:0] hnd_ext;
    assign hnd_ext = 32'(r_req.handle_in);

    krwl_pkg::t_out_word res;
    logic [ENTRIES-1:0] n_valid_bits;
    always_comb begin
        we = 1'b0;
        waddr = r_hit_idx;
        wrow = r_hit_row;
        res = '0;
        n_valid_bits = r_valid_bits;
        res.handle_out = krwl_pkg::HND_W'(r_hit_idx);
        unique case (r_req.opcode)
            krwl_pkg::OP_QUERY: begin
                res.status = krwl_pkg::ST_QUERY;
                res.handle_out = '0;
                res.is_held = r_held;
            end
            krwl_pkg::OP_UNLOCK: begin
                res.handle_out = r_req.handle_in;
                res.status = krwl_pkg::ST_MISUSE;
                if (hnd_ext < 32'(ENTRIES) && r_valid_bits[r_hit_idx]) begin
                    if (r_hit_row.wr != '0) begin
                        if (r_hit_row.owner == r_req.requester && r_hit_row.rd == '0) begin
                            res.status = krwl_pkg::ST_RELEASED;
                            wrow.wr = r_hit_row.wr - 1'b1;
                            res.wake_waiters = (wrow.wr == '0);
                        end
                    end else if (r_hit_row.rd != '0) begin
                        res.status = krwl_pkg::ST_RELEASED;
                        wrow.rd = r_hit_row.rd - 1'b1;
                        res.wake_waiters = (wrow.rd == '0);
                    end
                    if (res.status == krwl_pkg::ST_RELEASED) begin
                        we = 1'b1;
                        if (res.wake_waiters) begin
                            wrow.owner = '0;
                        end
                        if (r_hit_row.refs != '0) begin
                            wrow.refs = r_hit_row.refs - 1'b1;
                        end
                        if (wrow.refs == '0) begin
                            n_valid_bits[r_hit_idx] = 1'b0;
                        end
                    end
                end
            end
            default: begin
                if (!r_hit) begin
                    if (!free_any) begin
                        res.status = krwl_pkg::ST_FULL;
                        res.handle_out = '0;
                    end else begin
                        we = 1'b1;
                        waddr = free_idx;
                        wrow.key = r_req.lock_key;
                        wrow.refs = COUNT_BITS'(1);
                        wrow.rd = (r_req.opcode == krwl_pkg::OP_LOCK_SH) ? COUNT_BITS'(1) : '0;
                        wrow.wr = (r_req.opcode == krwl_pkg::OP_LOCK_EX) ? COUNT_BITS'(1) : '0;
                        wrow.owner = r_req.requester;
                        n_valid_bits[free_idx] = 1'b1;
                        res.status = krwl_pkg::ST_GRANTED;
                        res.handle_out = krwl_pkg::HND_W'(free_idx);
                    end
                end else if (r_req.opcode == krwl_pkg::OP_LOCK_EX) begin
                    if (r_hit_row.rd != '0 || (r_hit_row.wr != '0
                            && r_hit_row.owner != r_req.requester)) begin
                        res.status = krwl_pkg::ST_BLOCKED;
                    end else if (r_hit_row.refs == CMAX || r_hit_row.wr == CMAX) begin
                        res.status = krwl_pkg::ST_OVERFLOW;
                    end else begin
                        we = 1'b1;
                        wrow.wr = r_hit_row.wr + 1'b1;
                        wrow.refs = r_hit_row.refs + 1'b1;
                        wrow.owner = r_req.requester;
                        res.status = krwl_pkg::ST_GRANTED;
                    end
                end else begin
                    if (r_hit_row.wr != '0) begin
                        res.status = krwl_pkg::ST_BLOCKED;
                    end else if (r_hit_row.refs == CMAX || r_hit_row.rd == CMAX) begin
                        res.status = krwl_pkg::ST_OVERFLOW;
                    end else begin
                        we = 1'b1;
                        wrow.rd = r_hit_row.rd + 1'b1;
                        wrow.refs = r_hit_row.refs + 1'b1;
                        wrow.owner = r_req.requester;
                        res.status = krwl_pkg::ST_GRANTED;
                    end
                end
            end
        endcase
        if (r_state != S_EXEC) begin
            we = 1'b0;
            n_valid_bits = r_valid_bits;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_valid_bits <= '0;
            r_ovalid <= 1'b0;
            r_rd_pend <= 1'b0;
            r_scan <= '0;
        end else begin
            r_valid_bits <= n_valid_bits;
            if (r_ovalid && i_ready) begin
                r_ovalid <= 1'b0;
            end
            r_rd_pend <= 1'b0;
            unique case (r_state)
                S_IDLE: begin
                    if (i_valid && o_ready) begin
                        r_req <= i_data;
                        r_hit <= 1'b0;
                        r_held <= 1'b0;
                        r_scan <= '0;
                        if (i_data.opcode == krwl_pkg::OP_UNLOCK) begin
                            r_hit_idx <= AW'(i_data.handle_in);
                            r_state <= S_READ;
                        end else begin
                            r_state <= S_SCAN;
                        end
                    end
                end
                S_SCAN: begin
                    if (r_scan < (AW + 1)'(ENTRIES)) begin
                        r_raddr_q <= r_scan[AW-1:0];
                        r_rd_pend <= 1'b1;
                        r_scan <= r_scan + 1'b1;
                    end
                    if (r_rd_pend && r_valid_bits[r_raddr_q]
                            && rrow.key == r_req.lock_key) begin
                        if (!r_hit) begin
                            r_hit <= 1'b1;
                            r_hit_idx <= r_raddr_q;
                            r_hit_row <= rrow;
                        end
                        if (rrow.owner == r_req.requester) begin
                            r_held <= 1'b1;
                        end
                    end
                    if (!r_rd_pend && r_scan == (AW + 1)'(ENTRIES)) begin
                        r_state <= S_EXEC;
                    end
                end
                S_READ: begin
                    r_state <= S_OUT;
                end
                S_OUT: begin
                    r_hit_row <= rrow;
                    r_state <= S_EXEC;
                end
                S_EXEC: begin
                    r_odata <= res;
                    r_ovalid <= 1'b1;
                    r_state <= S_IDLE;
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

endmodule

@@ src/krwl_checker.sv @@
// Port checker for the keyed reader/writer lock table, bound to the top level.
// Depends on krwl_pkg and keyed_rw_lock_table.
module krwl_checker (
    input logic                i_clk,
    input logic                i_rst_n,
    input logic                i_valid,
    input logic                o_ready,
    input logic                o_valid,
    input logic                i_ready,
    input krwl_pkg::t_out_word o_data
);

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_data))
        else $error("Result word changed while stalled.");

    a_no_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && o_ready |=> !o_ready)
        else $error("Second word accepted while one is in work.");

    a_held_only_query: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_data.is_held |-> o_data.status == krwl_pkg::ST_QUERY)
        else $error("Held flag on a non-query result.");

    a_wake_released: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_data.wake_waiters |-> o_data.status == krwl_pkg::ST_RELEASED)
        else $error("Wakeup on a result that released nothing.");

endmodule

bind keyed_rw_lock_table krwl_checker u_krwl_checker (
    .i_clk  (i_clk),
    .i_rst_n(i_rst_n),
    .i_valid(i_valid),
    .o_ready(o_ready),
    .o_valid(o_valid),
    .i_ready(i_ready),
    .o_data (o_data)
);
